// ===== hw/rtl/dfi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_pkg: shared definitions for the direct-form IIR filter
// Coefficient format, register indexes, defaults and the cell control bundle.
// ----------------------------------------------------------------------------
package dfi_pkg;

   localparam int COEF_W         = 16;
   localparam int COEF_FRAC      = 13;
   localparam int NUM_TAPS       = 3;
   localparam int NUM_REGS       = 7;
   localparam int CSR_INDEX_W    = 3;
   localparam int GUARD_W        = 3;
   localparam int DEF_SAMPLE_W   = 16;
   localparam int DEF_FF_ORDER   = 3;
   localparam int DEF_FB_ORDER   = 3;

   // 1.0 in Q3.13
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_COEF_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_COEF_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_COEF_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_COEF_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FB_COEF_1 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FB_COEF_2 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FB_COEF_3 = 3'd6;

   // Control shared by every cell of the partial-sum chain
   typedef struct packed {
      logic advance;   // a sample is retired this cycle
      logic clear;     // sample starts a new vector: drop old partial sums
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/direct_form_iir_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_form_iir_filter_top: third-order direct-form-I IIR filter
// Computes y = b0*x + b1*x1 + b2*x2 + b3*x3 - a1*y1 - a2*y2 - a3*y3 on a
// stream of Q1.15 samples with Q3.13 coefficients already scaled by 1/a0.
//
// Samples enter on req_* (sample in tdata, start-of-vector flag in tuser);
// a set flag restarts both histories from rest before that sample.
// Results leave on rsp_* (filtered sample in tdata, clip flag in tuser),
// rounded to nearest (ties up) and saturated to the sample range.
// Coefficients are written on csr_* (index 0..6: b0..b3, a1..a3); the user
// must write only while no sample is in flight, which the block does not
// enforce; writes to other indexes are dropped. csr_ready is always high.
// One sample per cycle while the result buffer is not full; a result is
// offered from the result buffer behind the product stage. The feedback
// loop of output rounding and the three partial-sum cells sets the rate.
// Reset clears the partial sums (histories) and loads b0 = 1.0, all other
// coefficients 0. A stalled receiver is absorbed by a two-entry result
// buffer; req_tready drops once it and the product stage are full.
// ----------------------------------------------------------------------------
module direct_form_iir_filter_top #(
   parameter int SAMPLE_W = dfi_pkg::DEF_SAMPLE_W,
   parameter int FF_ORDER = dfi_pkg::DEF_FF_ORDER,
   parameter int FB_ORDER = dfi_pkg::DEF_FB_ORDER
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_W+7)/8)*8-1:0]       req_tdata,   // sample_in
   input  logic                                req_tuser,   // start_of_vector
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_W+7)/8)*8-1:0]       rsp_tdata,   // filtered_sample
   output logic                                rsp_tuser,   // saturated
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dfi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dfi_pkg::COEF_W-1:0]          csr_data
);
   import dfi_pkg::*;

   localparam int TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int PROD_W  = SAMPLE_W + COEF_W;
   localparam int ACC_W   = PROD_W + GUARD_W;
   localparam int YW_W    = ACC_W - COEF_FRAC;

   logic [COEF_W-1:0]          coef_ff [NUM_REGS];

   logic                       stage_valid_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       sof_ff;
   logic signed [PROD_W-1:0]   p0_ff;

   logic                       req_xfer;
   logic                       advance;
   logic                       buf_full;
   cell_ctrl_type              cell_ctrl;

   logic signed [ACC_W-1:0]    chain_sum [1:NUM_TAPS+1];
   logic signed [ACC_W-1:0]    head_sum;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [YW_W-1:0]     y_wide;
   logic                       y_ovf;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic [SAMPLE_W:0]          buf_data;

   // ---------------- coefficient registers ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[CSR_FF_COEF_0] <= COEF_ONE;
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(NUM_REGS))) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   // ---------------- product stage: b0*x ----------------
   assign advance    = stage_valid_ff && !buf_full;
   assign req_tready = !stage_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_ff   <= signed'(req_tdata[SAMPLE_W-1:0]);
         sof_ff <= req_tuser;
         p0_ff  <= signed'(coef_ff[CSR_FF_COEF_0]) * signed'(req_tdata[SAMPLE_W-1:0]);
      end
   end

   // ---------------- output: round, saturate ----------------
   assign head_sum = sof_ff ? '0 : chain_sum[1];
   assign acc      = ACC_W'(p0_ff) + head_sum;
   assign acc_rnd  = acc + ACC_W'(1 << (COEF_FRAC - 1));
   // floor division by 2^COEF_FRAC
   assign y_wide   = acc_rnd[ACC_W-1:COEF_FRAC];
   assign y_ovf    = !((&y_wide[YW_W-1:SAMPLE_W-1]) || !(|y_wide[YW_W-1:SAMPLE_W-1]));

   always_comb begin
      if (!y_ovf) begin
         y_sat = y_wide[SAMPLE_W-1:0];
      end else if (y_wide[YW_W-1]) begin
         y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   // ---------------- partial-sum chain ----------------
   assign cell_ctrl.advance     = advance;
   assign cell_ctrl.clear       = sof_ff;
   assign chain_sum[NUM_TAPS+1] = '0;

   for (genvar k = 1; k <= NUM_TAPS; k++) begin : g_tap
      dfi_tap_cell #(
         .SAMPLE_W (SAMPLE_W),
         .FF_EN    (k <= FF_ORDER),
         .FB_EN    (k <= FB_ORDER)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .x_sample (x_ff),
         .y_sample (y_sat),
         .ff_coef  (signed'(coef_ff[k])),
         .fb_coef  (signed'(coef_ff[NUM_TAPS + k])),
         .sum_in   (chain_sum[k+1]),
         .sum_out  (chain_sum[k])
      );
   end

   // ---------------- result buffer ----------------
   dfi_rsp_buf #(
      .DATA_W (SAMPLE_W + 1)
   ) u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data ({y_ovf, y_sat}),
      .full      (buf_full),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (buf_data)
   );

   assign rsp_tdata = TDATA_W'(buf_data[SAMPLE_W-1:0]);
   assign rsp_tuser = buf_data[SAMPLE_W];

endmodule

// ===== hw/rtl/dfi_tap_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_tap_cell: one tap of the partial-sum chain
// Holds the running sum b_k*x - a_k*y plus the sum of the next cell,
// and hands it to the neighbor closer to the output on every retired sample.
// ----------------------------------------------------------------------------
module dfi_tap_cell #(
   parameter int SAMPLE_W = dfi_pkg::DEF_SAMPLE_W,
   parameter bit FF_EN    = 1'b1,
   parameter bit FB_EN    = 1'b1
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  dfi_pkg::cell_ctrl_type                                   ctrl,
   input  logic signed [SAMPLE_W-1:0]                               x_sample,
   input  logic signed [SAMPLE_W-1:0]                               y_sample,
   input  logic signed [dfi_pkg::COEF_W-1:0]                        ff_coef,
   input  logic signed [dfi_pkg::COEF_W-1:0]                        fb_coef,
   input  logic signed [SAMPLE_W+dfi_pkg::COEF_W+dfi_pkg::GUARD_W-1:0] sum_in,
   output logic signed [SAMPLE_W+dfi_pkg::COEF_W+dfi_pkg::GUARD_W-1:0] sum_out
);
   import dfi_pkg::*;

   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + GUARD_W;

   logic signed [COEF_W-1:0] ff_coef_eff;
   logic signed [COEF_W-1:0] fb_coef_eff;
   logic signed [PROD_W-1:0] ff_prod;
   logic signed [PROD_W-1:0] fb_prod;
   logic signed [ACC_W-1:0]  sum_eff;
   logic signed [ACC_W-1:0]  sum_in_val;
   logic signed [ACC_W-1:0]  sum_ff;

   // Taps beyond the configured order contribute nothing
   assign ff_coef_eff = FF_EN ? ff_coef : '0;
   assign fb_coef_eff = FB_EN ? fb_coef : '0;

   assign ff_prod = ff_coef_eff * x_sample;
   assign fb_prod = fb_coef_eff * y_sample;

   // Drop the older contribution at the start of a vector
   assign sum_eff    = ctrl.clear ? '0 : sum_in;
   assign sum_in_val = sum_eff + ACC_W'(ff_prod) - ACC_W'(fb_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.advance) begin
         sum_ff <= sum_in_val;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ===== hw/rtl/dfi_rsp_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_rsp_buf: two-entry result buffer
// Decouples the filter from the result receiver so one stalled result
// does not hold up the next sample.
// ----------------------------------------------------------------------------
module dfi_rsp_buf #(
   parameter int DATA_W = dfi_pkg::DEF_SAMPLE_W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import dfi_pkg::*;

   localparam int DEPTH = 2;

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'(DEPTH));
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sim/tb_direct_form_iir_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_form_iir_filter_top: self-checking bench for the direct-form IIR
// Walks a table of directed samples and coefficient writes (reset defaults,
// sample and coefficient extremes, clipping, rounding ties, an unmapped
// register), then runs random vectors under several coefficient sets. Every
// output transfer is compared with the row's typed-in value or a cycle-free
// fixed-point model kept in step with the accepted samples and coefficient
// writes. Both sides idle at random; the receiver also for a long stretch.
// ----------------------------------------------------------------------------
module tb_direct_form_iir_filter_top;
   import dfi_pkg::*;

   localparam int SAMPLE_W    = DEF_SAMPLE_W;
   localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 150;
   localparam int NUM_PHASES  = 6;
   localparam int NUM_ROWS    = 30;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   // only index the csr decoder leaves unmapped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       clipped;
   } filt_out_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef enum int {STYLE_TAME, STYLE_FULL, STYLE_EXTREME, STYLE_FIR} coef_style_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [15:0]              value;    // sample or coefficient
      logic                     sov;
      logic                     known;    // expected output typed in below
      logic [15:0]              y;
      logic                     sat;
   } stim_row_type;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h7fff, 1'b0, 1'b1, 16'h7fff, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h8000, 1'b0, 1'b1, 16'h8000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h0001, 1'b0, 1'b1, 16'h0001, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'hffff, 1'b0, 1'b1, 16'hffff, 1'b0},
      '{ROW_CSR,    CSR_UNMAPPED,  16'h7fff, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h3039, 1'b1, 1'b1, 16'h3039, 1'b0},
      '{ROW_CSR,    CSR_FF_COEF_0, 16'h7fff, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h7fff, 1'b1, 1'b1, 16'h7fff, 1'b1},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h8000, 1'b1, 1'b1, 16'h8000, 1'b1},
      '{ROW_CSR,    CSR_FF_COEF_0, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h8000, 1'b1, 1'b1, 16'h7fff, 1'b1},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h7fff, 1'b1, 1'b1, 16'h8000, 1'b1},
      '{ROW_CSR,    CSR_FF_COEF_0, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
      // rounding ties go up: +0.5 lsb gives 1, -0.5 lsb gives 0
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h1000, 1'b1, 1'b1, 16'h0001, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'hf000, 1'b1, 1'b1, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FF_COEF_1, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FF_COEF_2, 16'h7fff, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FF_COEF_3, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FB_COEF_1, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FB_COEF_2, 16'h7fff, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FB_COEF_3, 16'he000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR,    CSR_FF_COEF_0, 16'h2000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h4000, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'hc000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h7fff, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, CSR_FF_COEF_0, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [DATA_W-1:0]       req_tdata;   // sample_in
   logic                    req_tuser;   // start_of_vector
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [DATA_W-1:0]       rsp_tdata;   // filtered_sample
   logic                    rsp_tuser;   // saturated
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [COEF_W-1:0]       csr_data;

   // typed-in expectation travels alongside the sample
   logic                    req_known;
   logic [SAMPLE_W-1:0]     req_known_y;
   logic                    req_known_sat;

   logic signed [COEF_W-1:0]   coef_regs [NUM_REGS];
   logic signed [SAMPLE_W-1:0] x_hist [NUM_TAPS];
   logic signed [SAMPLE_W-1:0] y_hist [NUM_TAPS];
   filt_out_type               predicted_outputs [$];

   int errors = 0;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_requests = 0;
   int hold_served = 0;

   direct_form_iir_filter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("tb_direct_form_iir_filter_top: done, errors");
      $finish;
   end

   function automatic void clear_history();
      for (int i = 0; i < NUM_TAPS; i++) begin
         x_hist[i] = '0;
         y_hist[i] = '0;
      end
   endfunction

   function automatic filt_out_type iir_step(input logic signed [SAMPLE_W-1:0] x,
                                             input logic sov);
      longint       acc;
      filt_out_type r;
      if (sov) clear_history();
      acc = longint'(coef_regs[CSR_FF_COEF_0]) * longint'(x);
      for (int i = 1; i <= NUM_TAPS; i++) begin
         acc += longint'(coef_regs[i]) * longint'(x_hist[i-1]);
         acc -= longint'(coef_regs[NUM_TAPS+i]) * longint'(y_hist[i-1]);
      end
      // round to nearest, ties up, then clip to the sample range
      acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      r.clipped = (acc > SAMPLE_MAX) || (acc < SAMPLE_MIN);
      if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
      else if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
      r.value = acc[SAMPLE_W-1:0];
      for (int i = NUM_TAPS - 1; i > 0; i--) begin
         x_hist[i] = x_hist[i-1];
         y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = x;
      y_hist[0] = r.value;
      return r;
   endfunction

   // Track coefficient writes and samples, check every output transfer
   always @(posedge clock) begin
      filt_out_type want;
      filt_out_type got;
      if (reset) begin
         clear_history();
         foreach (coef_regs[i]) coef_regs[i] = '0;
         coef_regs[CSR_FF_COEF_0] = COEF_ONE;
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_REGS) coef_regs[csr_index] = csr_data;
         if (req_tvalid && req_tready) begin
            want = iir_step(req_tdata[SAMPLE_W-1:0], req_tuser);
            if (req_known) want = '{req_known_y, req_known_sat};
            predicted_outputs.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[SAMPLE_W-1:0], rsp_tuser};
            if (predicted_outputs.size() == 0) begin
               $error("rsp transfer with nothing expected: filtered_sample %0d saturated %0b",
                      got.value, got.clipped);
               errors++;
            end else begin
               want = predicted_outputs.pop_front();
               if (got.value !== want.value) begin
                  $error("filtered_sample: expected %0d, actual %0d", want.value, got.value);
                  errors++;
               end
               if (got.clipped !== want.clipped) begin
                  $error("saturated: expected %0b, actual %0b", want.clipped, got.clipped);
                  errors++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic sov,
                              input logic known, input logic [SAMPLE_W-1:0] y,
                              input logic sat);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= DATA_W'(x);
      req_tuser     <= sov;
      req_known     <= known;
      req_known_y   <= y;
      req_known_sat <= sat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write
   task automatic write_coef(input logic [CSR_INDEX_W-1:0] index, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Stop offering samples and wait for every expected output
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_outputs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef(input coef_style_type style,
                                                   input bit feedback);
      case (style)
         STYLE_TAME:
            return feedback ? COEF_W'($urandom_range(0, 4095) - 2048)
                            : COEF_W'($urandom_range(0, 8191) - 4096);
         STYLE_FULL:
            return COEF_W'($urandom);
         STYLE_EXTREME:
            case ($urandom_range(4))
               0:       return 16'h7fff;
               1:       return 16'h8000;
               2:       return '0;
               3:       return COEF_ONE;
               default: return 16'he000;
            endcase
         default:
            return feedback ? '0 : COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 70) return SAMPLE_W'($urandom);
      if (r < 85) return SAMPLE_W'($urandom_range(0, 511) - 256);
      case ($urandom_range(4))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'hffff;
      endcase
   endfunction

   initial begin
      int n;
      int len;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      req_known     = 1'b0;
      req_known_y   = '0;
      req_known_sat = 1'b0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_FF_COEF_0;
      csr_data      = '0;
      tx_idle_pct   = 7;
      rx_idle_pct   = 52;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            drain_outputs();
            write_coef(directed_rows[r].index, directed_rows[r].value);
            csr_valid <= 1'b0;
         end else begin
            send_sample(directed_rows[r].value, directed_rows[r].sov, directed_rows[r].known,
                        directed_rows[r].y, directed_rows[r].sat);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p / 2)
            0:       begin tx_idle_pct = 7;  rx_idle_pct = 52; end
            1:       begin tx_idle_pct = 52; rx_idle_pct = 7;  end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         drain_outputs();
         for (int i = 0; i < NUM_REGS; i++)
            write_coef(CSR_INDEX_W'(i), pick_coef(coef_style_type'(p % 4), i > NUM_TAPS));
         write_coef(CSR_UNMAPPED, COEF_W'($urandom));
         csr_valid <= 1'b0;
         n = 0;
         while (n < PHASE_ITEMS) begin
            len = $urandom_range(1, 40);
            for (int k = 0; k < len && n < PHASE_ITEMS; k++) begin
               if (p == 2 && n == PHASE_ITEMS / 2) drain_outputs();
               // fill the block while the receiver holds off
               if (p == 4 && n == 40) hold_requests++;
               send_sample(pick_sample(), k == 0 || $urandom_range(19) == 0, 1'b0, '0, 1'b0);
               n++;
            end
         end
      end

      drain_outputs();
      repeat (10) @(posedge clock);
      if (errors == 0 && predicted_outputs.size() == 0) begin
         $display("tb_direct_form_iir_filter_top: done, clean");
      end else begin
         $display("tb_direct_form_iir_filter_top: done, errors");
      end
      $finish;
   end

endmodule
